### design/ray_polyline_farthest_hit_defines.svh
// assertion macros used by the top-level design file
`ifndef RAY_POLYLINE_FARTHEST_HIT_DEFINES_SVH
`define RAY_POLYLINE_FARTHEST_HIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RPFH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpfh same-cycle check failed");
// next-cycle implication
`define RPFH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpfh next-cycle check failed");
`else
`define RPFH_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RPFH_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

### design/rpfh_pkg.sv
package rpfh_pkg;

    // coordinate formats
    localparam int CW    = 12;
    localparam int FW    = 8;
    localparam int QW    = CW + FW;
    localparam int DIRW  = 16;
    localparam int SIZEW = 13;
    localparam int MDW   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // internal widths
    localparam int UW   = CW + 1;
    localparam int W0W  = QW + 1;
    localparam int PAW  = UW + W0W;
    localparam int AW   = PAW + 1;
    localparam int AMW  = AW - 1;
    localparam int PBW  = UW + DIRW;
    localparam int BW   = PBW + 1;
    localparam int BMW  = BW - 1;
    localparam int PW   = AMW + DIRW;
    localparam int QN   = QW + 3;
    localparam int QOW  = QN + 1;
    localparam int OFFW = QOW + 1;
    localparam int IW   = OFFW + 1;
    localparam int WDW  = IW + 1;
    localparam int WPW  = WDW + UW;
    localparam int WUW  = WPW + 1;
    localparam int UPW  = 2 * UW;
    localparam int UUW  = UPW + 1 + FW;
    localparam int DPW  = 2 * OFFW;
    localparam int DW   = 48;
    localparam int CNTW = $clog2(QN + 1);

    localparam logic [QOW-1:0] OFF_LIMIT = QOW'(1) << (QW + 1);
    localparam logic signed [IW-1:0] HALF_PIX  = IW'(1) << (FW - 1);
    localparam logic signed [IW-1:0] THREE_HALF = IW'(3) << (FW - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_W      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_H      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_EDGES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEN    = 3'd7;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_SETUP, OP_MUL_A, OP_MUL_B, OP_SUB_B, OP_TEST,
        OP_MUL_PX, OP_DIVX_GO, OP_DIVX_WAIT, OP_MUL_PY, OP_DIVY_GO,
        OP_DIVY_WAIT, OP_POS, OP_MUL_W, OP_MUL_U, OP_MUL_D, OP_UPDATE,
        OP_ADVANCE, OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SETUP, ST_MUL_A, ST_MUL_B, ST_SUB_B, ST_TEST,
        ST_MUL_PX, ST_DIVX_GO, ST_DIVX_WAIT, ST_MUL_PY, ST_DIVY_GO,
        ST_DIVY_WAIT, ST_POS, ST_MUL_W, ST_MUL_U, ST_MUL_D, ST_UPDATE,
        ST_SEG_END, ST_EMIT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic close;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic reject;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### design/rpfh_div.sv
module rpfh_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rpfh_pkg::PW-1:0]  dividend,
    input  logic [rpfh_pkg::BMW-1:0] divisor,
    output logic                     done,
    output logic                     overflow,
    output logic [rpfh_pkg::QOW-1:0] quotient
);
    import rpfh_pkg::*;

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [BMW-1:0]  rem_reg, rem_next;
    logic [QN-1:0]   low_reg, low_next;
    logic [QN-1:0]   q_reg, q_next;
    logic            ovf_reg, ovf_next;
    logic [BMW-1:0]  dvs_reg, dvs_next;
    logic [BMW:0]    trial;
    logic            round_up;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        dvs_reg <= dvs_next;
    end

    // one quotient bit per cycle, restoring
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, low_reg[QN-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = BMW'(dividend[PW-1:QN]);
            low_next  = dividend[QN-1:0];
            q_next    = '0;
            dvs_next  = divisor;
            ovf_next  = ({{(BMW-(PW-QN)){1'b0}}, dividend[PW-1:QN]} >= divisor);
        end else if (busy_reg) begin
            if (cnt_reg == CNTW'(QN)) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                low_next = {low_reg[QN-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = BMW'(trial - {1'b0, dvs_reg});
                    q_next   = {q_reg[QN-2:0], 1'b1};
                end else begin
                    rem_next = trial[BMW-1:0];
                    q_next   = {q_reg[QN-2:0], 1'b0};
                end
            end
        end
    end

    // round to nearest, ties away from zero
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, dvs_reg});
    assign quotient = {1'b0, q_reg} + QOW'(round_up);
    assign overflow = ovf_reg;
    assign done     = busy_reg && (cnt_reg == CNTW'(QN));

endmodule

### design/rpfh_ctrl.sv
module rpfh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpfh_pkg::status_t status,
    output rpfh_pkg::cmd_t    cmd
);
    import rpfh_pkg::*;

    state_t state_reg, state_next;
    logic   close_reg, close_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            close_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        close_next = close_reg;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.close  = close_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                    if (status.have_prev) begin
                        close_next = 1'b0;
                        state_next = ST_SETUP;
                    end else begin
                        close_next = 1'b0;
                        state_next = ST_SEG_END;
                    end
                end
            end
            ST_SETUP: begin
                cmd.op = OP_SETUP;
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.op = OP_MUL_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.op = OP_MUL_B;
                state_next = ST_SUB_B;
            end
            ST_SUB_B: begin
                cmd.op = OP_SUB_B;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.op = OP_TEST;
                state_next = status.reject ? ST_SEG_END : ST_MUL_PX;
            end
            ST_MUL_PX: begin
                cmd.op = OP_MUL_PX;
                state_next = ST_DIVX_GO;
            end
            ST_DIVX_GO: begin
                cmd.op = OP_DIVX_GO;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT: begin
                cmd.op = OP_DIVX_WAIT;
                if (status.div_done) begin
                    state_next = ST_MUL_PY;
                end
            end
            ST_MUL_PY: begin
                cmd.op = OP_MUL_PY;
                state_next = ST_DIVY_GO;
            end
            ST_DIVY_GO: begin
                cmd.op = OP_DIVY_GO;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT: begin
                cmd.op = OP_DIVY_WAIT;
                if (status.div_done) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                cmd.op = OP_POS;
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.op = OP_MUL_W;
                state_next = ST_MUL_U;
            end
            ST_MUL_U: begin
                cmd.op = OP_MUL_U;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.op = OP_MUL_D;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.op = OP_UPDATE;
                state_next = ST_SEG_END;
            end
            // after a segment or a first vertex: closing segment, result or next vertex
            ST_SEG_END: begin
                cmd.op = OP_ADVANCE;
                if (status.last && !close_reg) begin
                    close_next = 1'b1;
                    state_next = ST_SETUP;
                end else if (status.last) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_EMIT;
                    close_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/rpfh_dp.sv
module rpfh_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rpfh_pkg::cmd_t                  cmd,
    output rpfh_pkg::status_t               status,
    input  logic [rpfh_pkg::CW-1:0]         s_point_x,
    input  logic [rpfh_pkg::CW-1:0]         s_point_y,
    input  logic                            s_last_point,
    input  logic                            cfg_valid,
    input  logic [rpfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpfh_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [rpfh_pkg::QW-1:0]         m_hit_x,
    output logic [rpfh_pkg::QW-1:0]         m_hit_y
);
    import rpfh_pkg::*;

    // configuration
    logic [QW-1:0]           origin_x_reg, origin_y_reg;
    logic signed [DIRW-1:0]  dir_x_reg, dir_y_reg;
    logic [SIZEW-1:0]        img_w_reg, img_h_reg;
    logic                    excl_reg;
    logic [MDW-1:0]          min_den_reg;

    // polyline state
    logic [CW-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [CW-1:0] cur_x_reg, cur_y_reg;
    logic          have_prev_reg, last_reg, hit_seen_reg;
    logic [DW-1:0] best_dist_reg;
    logic [QW-1:0] best_x_reg, best_y_reg;

    // segment datapath
    logic [QW-1:0]           axq_reg, ayq_reg;
    logic signed [UW-1:0]    ux_reg, uy_reg;
    logic signed [W0W-1:0]   w0x_reg, w0y_reg;
    logic signed [PAW-1:0]   pa1_reg, pa2_reg;
    logic signed [AW-1:0]    a_reg;
    logic signed [PBW-1:0]   pb1_reg, pb2_reg;
    logic signed [BW-1:0]    b_reg;
    logic [AMW-1:0]          amag_reg;
    logic [BMW-1:0]          bmag_reg;
    logic [PW-1:0]           prod_reg;
    logic [QOW-1:0]          qx_reg, qy_reg;
    logic                    ovfx_reg, ovfy_reg;
    logic signed [OFFW-1:0]  offx_reg, offy_reg;
    logic signed [IW-1:0]    ix_reg, iy_reg;
    logic                    far_reg;
    logic signed [WPW-1:0]   wp1_reg, wp2_reg;
    logic signed [WUW-1:0]   wu_reg;
    logic signed [UPW-1:0]   up1_reg, up2_reg;
    logic signed [UUW-1:0]   uu_reg;
    logic signed [DPW-1:0]   dp1_reg, dp2_reg;

    // output register
    logic          m_valid_reg;
    logic          m_found_reg;
    logic [QW-1:0] m_hit_x_reg, m_hit_y_reg;

    // combinational helpers
    logic [CW-1:0]          sel_ax, sel_ay, sel_bx, sel_by;
    logic [AMW-1:0]         amag;
    logic [BMW-1:0]         bmag;
    logic [DIRW-1:0]        dxmag, dymag;
    logic                   reject;
    logic                   div_start, div_done, div_ovf;
    logic [QOW-1:0]         div_q;
    logic signed [OFFW-1:0] offx, offy;
    logic signed [WDW-1:0]  wdx, wdy;
    logic signed [IW-1:0]   hxv, hyv;
    logic                   edge_ok, hit_ok;
    logic [DW-1:0]          dist_sq;
    logic [QW-1:0]          satx, saty;

    // endpoints: open segment prev to cur, closing segment cur to first
    assign sel_ax = cmd.close ? cur_x_reg   : prev_x_reg;
    assign sel_ay = cmd.close ? cur_y_reg   : prev_y_reg;
    assign sel_bx = cmd.close ? first_x_reg : cur_x_reg;
    assign sel_by = cmd.close ? first_y_reg : cur_y_reg;

    // magnitudes
    assign amag  = a_reg[AW-1] ? AMW'(-a_reg) : AMW'(a_reg);
    assign bmag  = b_reg[BW-1] ? BMW'(-b_reg) : BMW'(b_reg);
    assign dxmag = dir_x_reg[DIRW-1] ? DIRW'(-dir_x_reg) : DIRW'(dir_x_reg);
    assign dymag = dir_y_reg[DIRW-1] ? DIRW'(-dir_y_reg) : DIRW'(dir_y_reg);

    // early rejection: degenerate, small denominator, ray parameter not positive
    assign reject = ((ux_reg == '0) && (uy_reg == '0))
                  || (bmag <= BMW'(min_den_reg))
                  || (a_reg == '0)
                  || (a_reg[AW-1] != b_reg[BW-1]);

    // shared divider
    assign div_start = (cmd.op == OP_DIVX_GO) || (cmd.op == OP_DIVY_GO);

    rpfh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (bmag_reg),
        .done     (div_done),
        .overflow (div_ovf),
        .quotient (div_q)
    );

    // signed offsets
    assign offx = dir_x_reg[DIRW-1] ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign offy = dir_y_reg[DIRW-1] ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});

    // hit point relative to segment start
    assign wdx = {ix_reg[IW-1], ix_reg} - $signed({{(WDW-QW){1'b0}}, axq_reg});
    assign wdy = {iy_reg[IW-1], iy_reg} - $signed({{(WDW-QW){1'b0}}, ayq_reg});

    // image bounds with low and high margins
    assign hxv = $signed({{(IW-SIZEW-FW){1'b0}}, img_w_reg, {FW{1'b0}}}) - THREE_HALF;
    assign hyv = $signed({{(IW-SIZEW-FW){1'b0}}, img_h_reg, {FW{1'b0}}}) - THREE_HALF;
    assign edge_ok = !excl_reg
                   || ((ix_reg > HALF_PIX) && (ix_reg < hxv)
                       && (iy_reg > HALF_PIX) && (iy_reg < hyv));

    assign hit_ok  = !far_reg && !wu_reg[WUW-1]
                   && (wu_reg <= WUW'(uu_reg)) && edge_ok;
    assign dist_sq = DW'(dp1_reg) + DW'(dp2_reg);

    // saturate to the output range
    assign satx = ix_reg[IW-1] ? '0
                : ((ix_reg[IW-2:QW] != '0) ? {QW{1'b1}} : ix_reg[QW-1:0]);
    assign saty = iy_reg[IW-1] ? '0
                : ((iy_reg[IW-2:QW] != '0) ? {QW{1'b1}} : iy_reg[QW-1:0]);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            dir_x_reg    <= DIRW'(16384);
            dir_y_reg    <= '0;
            img_w_reg    <= SIZEW'(4096);
            img_h_reg    <= SIZEW'(4096);
            excl_reg     <= 1'b1;
            min_den_reg  <= MDW'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg <= cfg_data[QW-1:0];
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data[QW-1:0];
                REG_DIR_X:      dir_x_reg    <= cfg_data[DIRW-1:0];
                REG_DIR_Y:      dir_y_reg    <= cfg_data[DIRW-1:0];
                REG_IMG_W:      img_w_reg    <= cfg_data[SIZEW-1:0];
                REG_IMG_H:      img_h_reg    <= cfg_data[SIZEW-1:0];
                REG_EXCL_EDGES: excl_reg     <= cfg_data[0];
                REG_MIN_DEN:    min_den_reg  <= cfg_data[MDW-1:0];
                default: ;
            endcase
        end
    end

    // polyline and best-hit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            hit_seen_reg  <= 1'b0;
            last_reg      <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            best_dist_reg <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end else begin
            if (cmd.op == OP_LATCH) begin
                last_reg <= s_last_point;
                if (!have_prev_reg) begin
                    first_x_reg <= s_point_x;
                    first_y_reg <= s_point_y;
                end
            end
            if (cmd.op == OP_ADVANCE) begin
                prev_x_reg    <= cur_x_reg;
                prev_y_reg    <= cur_y_reg;
                have_prev_reg <= 1'b1;
            end
            if ((cmd.op == OP_UPDATE) && hit_ok
                && (!hit_seen_reg || (dist_sq > best_dist_reg))) begin
                hit_seen_reg  <= 1'b1;
                best_dist_reg <= dist_sq;
                best_x_reg    <= satx;
                best_y_reg    <= saty;
            end
            if (cmd.op == OP_EMIT) begin
                have_prev_reg <= 1'b0;
                hit_seen_reg  <= 1'b0;
                last_reg      <= 1'b0;
                first_x_reg   <= '0;
                first_y_reg   <= '0;
                prev_x_reg    <= '0;
                prev_y_reg    <= '0;
                best_dist_reg <= '0;
                best_x_reg    <= '0;
                best_y_reg    <= '0;
            end
        end
    end

    // segment arithmetic, one step per command
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LATCH: begin
                cur_x_reg <= s_point_x;
                cur_y_reg <= s_point_y;
            end
            OP_SETUP: begin
                ux_reg  <= $signed({1'b0, sel_bx}) - $signed({1'b0, sel_ax});
                uy_reg  <= $signed({1'b0, sel_by}) - $signed({1'b0, sel_ay});
                axq_reg <= {sel_ax, {FW{1'b0}}};
                ayq_reg <= {sel_ay, {FW{1'b0}}};
                w0x_reg <= $signed({1'b0, origin_x_reg}) - $signed({1'b0, sel_ax, {FW{1'b0}}});
                w0y_reg <= $signed({1'b0, origin_y_reg}) - $signed({1'b0, sel_ay, {FW{1'b0}}});
            end
            OP_MUL_A: begin
                pa1_reg <= ux_reg * w0y_reg;
                pa2_reg <= uy_reg * w0x_reg;
            end
            OP_MUL_B: begin
                a_reg   <= AW'(pa1_reg) - AW'(pa2_reg);
                pb1_reg <= uy_reg * dir_x_reg;
                pb2_reg <= ux_reg * dir_y_reg;
            end
            OP_SUB_B: begin
                b_reg <= BW'(pb1_reg) - BW'(pb2_reg);
            end
            OP_TEST: begin
                amag_reg <= amag;
                bmag_reg <= bmag;
            end
            OP_MUL_PX: begin
                prod_reg <= amag_reg * dxmag;
            end
            OP_DIVX_WAIT: begin
                if (div_done) begin
                    qx_reg   <= div_q;
                    ovfx_reg <= div_ovf;
                end
            end
            OP_MUL_PY: begin
                prod_reg <= amag_reg * dymag;
            end
            OP_DIVY_WAIT: begin
                if (div_done) begin
                    qy_reg   <= div_q;
                    ovfy_reg <= div_ovf;
                end
            end
            OP_POS: begin
                offx_reg <= offx;
                offy_reg <= offy;
                ix_reg   <= $signed({{(IW-QW){1'b0}}, origin_x_reg}) + IW'(offx);
                iy_reg   <= $signed({{(IW-QW){1'b0}}, origin_y_reg}) + IW'(offy);
                far_reg  <= ovfx_reg || ovfy_reg || (qx_reg > OFF_LIMIT)
                          || (qy_reg > OFF_LIMIT);
            end
            OP_MUL_W: begin
                wp1_reg <= wdx * ux_reg;
                wp2_reg <= wdy * uy_reg;
            end
            OP_MUL_U: begin
                wu_reg  <= WUW'(wp1_reg) + WUW'(wp2_reg);
                up1_reg <= ux_reg * ux_reg;
                up2_reg <= uy_reg * uy_reg;
            end
            OP_MUL_D: begin
                uu_reg  <= $signed({(UUW-FW)'(up1_reg) + (UUW-FW)'(up2_reg), {FW{1'b0}}});
                dp1_reg <= offx_reg * offx_reg;
                dp2_reg <= offy_reg * offy_reg;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            m_found_reg <= hit_seen_reg;
            m_hit_x_reg <= hit_seen_reg ? best_x_reg : '0;
            m_hit_y_reg <= hit_seen_reg ? best_y_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_hit_x = m_hit_x_reg;
    assign m_hit_y = m_hit_y_reg;

    // status to the controller
    assign status.have_prev = have_prev_reg;
    assign status.last      = last_reg;
    assign status.reject    = reject;
    assign status.div_done  = div_done;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

### design/ray_polyline_farthest_hit.sv
// channel    | direction | payload                               | handshake
// s_ (input) | in        | s_point_x, s_point_y, s_last_point    | s_valid / s_ready
// m_ (result)| out       | m_found, m_hit_x, m_hit_y             | m_valid / m_ready
// cfg_       | in        | cfg_index, cfg_data                   | cfg_valid / cfg_ready
//
// one vertex at a time; a segment that reaches the shared bit-serial divider keeps
// ready low through two 23-step divisions and the multiply steps, a segment rejected
// early through the setup to test states and the segment end, a first vertex through
// the segment end alone; a last vertex also runs the closing segment before the result
// reset is synchronous and active low; a full output register stalls only the emit,
// so a new vertex is taken while a result waits; configuration writes always accepted
`include "ray_polyline_farthest_hit_defines.svh"

module ray_polyline_farthest_hit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rpfh_pkg::CW-1:0]         s_point_x,
    input  logic [rpfh_pkg::CW-1:0]         s_point_y,
    input  logic                            s_last_point,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [rpfh_pkg::QW-1:0]         m_hit_x,
    output logic [rpfh_pkg::QW-1:0]         m_hit_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rpfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpfh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpfh_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    rpfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and state
    rpfh_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_last_point (s_last_point),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_hit_x      (m_hit_x),
        .m_hit_y      (m_hit_y)
    );

    // a vertex request always leaves the idle state, so ready drops next cycle
    `RPFH_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a miss reports a zero point
    `RPFH_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid && !m_found,
        (m_hit_x == '0) && (m_hit_y == '0))
    // a vertex that does not close the polyline never raises a result next cycle
    `RPFH_ASSERT_NXT(a_no_early_result, aclk, aresetn,
        s_valid && s_ready && !s_last_point, !$rose(m_valid))

endmodule
